### src/wpsd_pkg.sv
// Shared types and constants for the WAV 8-bit PCM stream decoder.
package wpsd_pkg;

   // Parser phases, one-hot
   typedef enum logic [6:0] {
      PH_HEADER    = 7'b0000001,
      PH_CHUNK_HDR = 7'b0000010,
      PH_FMT       = 7'b0000100,
      PH_SKIP      = 7'b0001000,
      PH_DATA      = 7'b0010000,
      PH_DONE      = 7'b0100000,
      PH_FAULT     = 7'b1000000
   } phase_type;

   typedef logic [2:0] status_type;

   localparam status_type ST_FRAME      = 3'd0;
   localparam status_type ST_TOO_SMALL  = 3'd1;
   localparam status_type ST_NOT_WAVE   = 3'd2;
   localparam status_type ST_NOT_PCM    = 3'd3;
   localparam status_type ST_BAD_DEPTH  = 3'd4;
   localparam status_type ST_NO_CHUNK   = 3'd5;

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [5:0]  HEADER_BYTES = 6'd44;
   localparam logic [31:0] FMT_MIN_LEN  = 32'd16;
   localparam logic [15:0] FORMAT_PCM   = 16'd1;
   localparam logic [15:0] DEPTH_8BIT   = 16'd8;
   localparam logic [15:0] SILENCE      = 16'h8000;
   localparam logic [11:0] GAIN_RESET   = 12'd256;

endpackage

### src/wav_pcm8_stream_decoder.sv
// WAV 8-bit PCM stream decoder: RIFF chunk parser, gain scaler and output skid buffer.

// Takes one WAV file byte per transfer and can accept a byte on every cycle that req_stall
// is low. Each byte updates the chunk parser in the cycle it is taken; a result (a stereo
// frame or a single error code) is registered and offered on the rsp_ side. A two-entry
// output buffer (output register plus skid register) separates the sides: req_stall rises
// only while the skid register holds a result, i.e. after the output has been stalled with
// a further result arriving. Samples are (byte - 128) * 256, scaled by csr gain in unsigned
// fixed point with GAIN_FRACTION_BITS fraction bits, truncated toward zero, saturated to
// 16 bits and returned offset binary. Only write the gain while no transfer is in flight.
module wav_pcm8_stream_decoder
   import wpsd_pkg::*;
#(
   parameter int GAIN_FRACTION_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [11:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_file_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_left_sample,
   output logic [15:0] rsp_right_sample,
   output status_type  rsp_status
);

   localparam logic signed [29:0] ROUND_BIAS =
      30'((30'sd1 <<< GAIN_FRACTION_BITS) - 30'sd1);

   function automatic logic [15:0] scale_byte(input logic [7:0] b, input logic [11:0] g);
      logic signed [8:0]  centred;
      logic signed [12:0] gs;
      logic signed [21:0] prod;
      logic signed [29:0] full;
      logic signed [29:0] quot;
      logic [15:0]        res;
      centred = $signed({1'b0, b}) - 9'sd128;
      gs      = $signed({1'b0, g});
      prod    = centred * gs;
      full    = $signed({prod, 8'b0});
      // bias negatives so the shift truncates toward zero
      quot    = (full + (full[29] ? ROUND_BIAS : 30'sd0)) >>> GAIN_FRACTION_BITS;
      if (quot > 30'sd32767) begin
         res = 16'hFFFF;
      end else if (quot < -30'sd32768) begin
         res = 16'h0000;
      end else begin
         res = quot[15:0] ^ SILENCE;
      end
      return res;
   endfunction

   logic [11:0] gain_ff;

   phase_type   phase_ff,         phase_in;
   logic [5:0]  bytes_seen_ff,    bytes_seen_in;
   logic [32:0] offset_ff,        offset_in;
   logic [31:0] tag_ff,           tag_in;
   logic [31:0] len_ff,           len_in;
   logic [15:0] format_ff,        format_in;
   logic [15:0] depth_ff,         depth_in;
   logic [15:0] channels_ff,      channels_in;
   logic        format_seen_ff,   format_seen_in;
   logic [31:0] data_left_ff,     data_left_in;
   logic [7:0]  held_left_ff,     held_left_in;
   logic        left_pending_ff,  left_pending_in;
   logic        fault_latched_ff, fault_latched_in;
   status_type  fault_code_ff,    fault_code_in;

   logic        out_valid_ff,  skid_valid_ff;
   logic [15:0] out_left_ff,   out_right_ff,   skid_left_ff,   skid_right_ff;
   status_type  out_status_ff, skid_status_ff;

   logic        accept, take;
   logic        res_valid, frame, mono;
   logic [15:0] res_left, res_right, scaled_a, scaled_b;
   status_type  res_status;
   logic [31:0] tag_shift, len_new;
   logic [32:0] offset_inc, skip_total;

   assign accept    = req_valid && !req_stall;
   assign take      = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;

   assign mono       = (channels_ff == 16'd1);
   assign tag_shift  = {tag_ff[23:0], req_file_byte};
   assign len_new    = {req_file_byte, len_ff[23:0]};
   assign offset_inc = offset_ff + 33'd1;
   assign skip_total = {1'b0, len_ff} + {32'b0, len_ff[0]};

   // left takes the held byte once a stereo pair completes
   assign scaled_a = scale_byte((mono || !left_pending_ff) ? req_file_byte : held_left_ff,
                                gain_ff);
   assign scaled_b = scale_byte(req_file_byte, gain_ff);

   always_comb begin
      phase_in         = phase_ff;
      bytes_seen_in    = bytes_seen_ff;
      offset_in        = offset_ff;
      tag_in           = tag_ff;
      len_in           = len_ff;
      format_in        = format_ff;
      depth_in         = depth_ff;
      channels_in      = channels_ff;
      format_seen_in   = format_seen_ff;
      data_left_in     = data_left_ff;
      held_left_in     = held_left_ff;
      left_pending_in  = left_pending_ff;
      fault_latched_in = fault_latched_ff;
      fault_code_in    = fault_code_ff;
      res_valid        = 1'b0;
      res_left         = SILENCE;
      res_right        = SILENCE;
      res_status       = ST_FRAME;
      frame            = 1'b0;

      if (accept) begin
         if (bytes_seen_ff < HEADER_BYTES) begin
            bytes_seen_in = bytes_seen_ff + 6'd1;
         end

         unique case (phase_ff)
            PH_HEADER: begin
               tag_in    = tag_shift;
               offset_in = offset_inc;
               if (offset_ff == 33'd3 && tag_shift != TAG_RIFF) begin
                  fault_code_in = ST_NOT_WAVE;
                  phase_in      = PH_FAULT;
               end else if (offset_ff == 33'd11) begin
                  if (tag_shift != TAG_WAVE) begin
                     fault_code_in = ST_NOT_WAVE;
                     phase_in      = PH_FAULT;
                  end else begin
                     phase_in  = PH_CHUNK_HDR;
                     offset_in = '0;
                     tag_in    = '0;
                     len_in    = '0;
                  end
               end
            end
            PH_CHUNK_HDR: begin
               offset_in = offset_inc;
               if (offset_ff < 33'd4) begin
                  tag_in = tag_shift;
               end else begin
                  unique case (offset_ff[1:0])
                     2'd0: len_in[7:0]   = req_file_byte;
                     2'd1: len_in[15:8]  = req_file_byte;
                     2'd2: len_in[23:16] = req_file_byte;
                     2'd3: len_in[31:24] = req_file_byte;
                     default: ;
                  endcase
               end
               if (offset_ff == 33'd7) begin
                  offset_in = '0;
                  if (tag_ff == TAG_FMT && len_new >= FMT_MIN_LEN) begin
                     phase_in = PH_FMT;
                  end else if (tag_ff == TAG_DATA) begin
                     if (!format_seen_ff) begin
                        fault_code_in = ST_NO_CHUNK;
                        phase_in      = PH_FAULT;
                     end else begin
                        data_left_in = len_new;
                        phase_in     = (len_new == 32'd0) ? PH_DONE : PH_DATA;
                     end
                  end else if (len_new == 32'd0) begin
                     tag_in = '0;
                     len_in = '0;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_FMT: begin
               offset_in = offset_inc;
               priority if (offset_ff == 33'd0) begin
                  format_in = {8'd0, req_file_byte};
               end else if (offset_ff == 33'd1) begin
                  format_in = {req_file_byte, format_ff[7:0]};
               end else if (offset_ff == 33'd2) begin
                  channels_in = {8'd0, req_file_byte};
               end else if (offset_ff == 33'd3) begin
                  channels_in = {req_file_byte, channels_ff[7:0]};
               end else if (offset_ff == 33'd14) begin
                  depth_in = {8'd0, req_file_byte};
               end else if (offset_ff == 33'd15) begin
                  depth_in = {req_file_byte, depth_ff[7:0]};
               end else begin
               end
               if (offset_ff == 33'd15 && format_ff != FORMAT_PCM) begin
                  fault_code_in = ST_NOT_PCM;
                  phase_in      = PH_FAULT;
               end else if (offset_ff == 33'd15 && depth_in != DEPTH_8BIT) begin
                  fault_code_in = ST_BAD_DEPTH;
                  phase_in      = PH_FAULT;
               end else begin
                  if (offset_ff == 33'd15) begin
                     format_seen_in = 1'b1;
                  end
                  if (offset_inc >= skip_total) begin
                     phase_in  = PH_CHUNK_HDR;
                     offset_in = '0;
                     tag_in    = '0;
                     len_in    = '0;
                  end
               end
            end
            PH_SKIP: begin
               offset_in = offset_inc;
               if (offset_inc >= skip_total) begin
                  phase_in  = PH_CHUNK_HDR;
                  offset_in = '0;
                  tag_in    = '0;
                  len_in    = '0;
               end
            end
            PH_DATA: begin
               data_left_in = data_left_ff - 32'd1;
               priority if (mono) begin
                  res_left  = scaled_a;
                  res_right = scaled_a;
                  frame     = 1'b1;
               end else if (left_pending_ff) begin
                  res_left        = scaled_a;
                  res_right       = scaled_b;
                  left_pending_in = 1'b0;
                  frame           = 1'b1;
               end else if (data_left_in == 32'd0 || req_last_byte) begin
                  // lone left byte at the end of the chunk
                  res_left = scaled_a;
                  frame    = 1'b1;
               end else begin
                  held_left_in    = req_file_byte;
                  left_pending_in = 1'b1;
               end
               if (data_left_in == 32'd0) begin
                  phase_in = PH_DONE;
               end
            end
            PH_DONE, PH_FAULT: begin
            end
            default: begin
            end
         endcase

         priority if (req_last_byte && bytes_seen_in < HEADER_BYTES) begin
            res_valid  = 1'b1;
            res_left   = SILENCE;
            res_right  = SILENCE;
            res_status = ST_TOO_SMALL;
         end else if (phase_in == PH_FAULT && !fault_latched_ff &&
                      bytes_seen_in >= HEADER_BYTES) begin
            res_valid        = 1'b1;
            res_left         = SILENCE;
            res_right        = SILENCE;
            res_status       = fault_code_in;
            fault_latched_in = 1'b1;
         end else if (req_last_byte && phase_in != PH_DATA && phase_in != PH_DONE &&
                      phase_in != PH_FAULT) begin
            res_valid  = 1'b1;
            res_left   = SILENCE;
            res_right  = SILENCE;
            res_status = ST_NO_CHUNK;
         end else if (frame) begin
            res_valid  = 1'b1;
            res_status = ST_FRAME;
         end else begin
         end

         // parser restarts after the final byte
         if (req_last_byte) begin
            phase_in         = PH_HEADER;
            bytes_seen_in    = '0;
            offset_in        = '0;
            tag_in           = '0;
            len_in           = '0;
            format_in        = '0;
            depth_in         = '0;
            channels_in      = 16'd1;
            format_seen_in   = 1'b0;
            data_left_in     = '0;
            held_left_in     = '0;
            left_pending_in  = 1'b0;
            fault_latched_in = 1'b0;
            fault_code_in    = ST_FRAME;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff          <= GAIN_RESET;
         phase_ff         <= PH_HEADER;
         bytes_seen_ff    <= '0;
         offset_ff        <= '0;
         tag_ff           <= '0;
         len_ff           <= '0;
         format_ff        <= '0;
         depth_ff         <= '0;
         channels_ff      <= 16'd1;
         format_seen_ff   <= 1'b0;
         data_left_ff     <= '0;
         held_left_ff     <= '0;
         left_pending_ff  <= 1'b0;
         fault_latched_ff <= 1'b0;
         fault_code_ff    <= ST_FRAME;
      end else begin
         if (csr_wr_en) begin
            gain_ff <= csr_wr_data;
         end
         phase_ff         <= phase_in;
         bytes_seen_ff    <= bytes_seen_in;
         offset_ff        <= offset_in;
         tag_ff           <= tag_in;
         len_ff           <= len_in;
         format_ff        <= format_in;
         depth_ff         <= depth_in;
         channels_ff      <= channels_in;
         format_seen_ff   <= format_seen_in;
         data_left_ff     <= data_left_in;
         held_left_ff     <= held_left_in;
         left_pending_ff  <= left_pending_in;
         fault_latched_ff <= fault_latched_in;
         fault_code_ff    <= fault_code_in;
      end
   end

   // Output register plus skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_left_ff   <= skid_left_ff;
            out_right_ff  <= skid_right_ff;
            out_status_ff <= skid_status_ff;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || take) begin
            out_left_ff   <= res_left;
            out_right_ff  <= res_right;
            out_status_ff <= res_status;
         end else begin
            skid_left_ff   <= res_left;
            skid_right_ff  <= res_right;
            skid_status_ff <= res_status;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_left_sample  = out_left_ff;
   assign rsp_right_sample = out_right_ff;
   assign rsp_status       = out_status_ff;

endmodule
